FILE: sv/usd_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the lead byte classifier for the utf-8 decoder
// no dependencies
package usd_pkg;

   localparam int OFFSET_BITS_DEFAULT = 32;
   localparam int QUEUE_DEPTH         = 4;
   localparam int QPTR_W              = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W              = $clog2(QUEUE_DEPTH + 1);
   localparam int WIN_DEPTH           = 4;

   localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
   localparam logic [20:0] CP_MIN_2       = 21'h000080;
   localparam logic [20:0] CP_MIN_3       = 21'h000800;
   localparam logic [20:0] CP_MIN_4       = 21'h010000;
   localparam logic [20:0] SURR_LO        = 21'h00D800;
   localparam logic [20:0] SURR_END       = 21'h00E000;
   localparam logic [20:0] CP_MAX         = 21'h10FFFF;

   localparam logic [7:0] TRAIL_MASK = 8'hC0;
   localparam logic [7:0] TRAIL_TAG  = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_TAG  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_TAG  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_TAG  = 8'hF0;

   // one byte after classification
   typedef struct packed {
      logic [7:0] data;
      logic       final_byte;
      logic [2:0] need;
      logic       trail;
   } byte_item_type;

   // head of the queue as seen by the back end
   typedef struct packed {
      logic          valid;
      byte_item_type item;
   } queue_head_type;

   function automatic logic [2:0] lead_need(input logic [7:0] b);
      logic [2:0] n;
      n = 3'd1;
      if ((b & LEAD2_MASK) == LEAD2_TAG) n = 3'd2;
      if ((b & LEAD3_MASK) == LEAD3_TAG) n = 3'd3;
      if ((b & LEAD4_MASK) == LEAD4_TAG) n = 3'd4;
      return n;
   endfunction

endpackage

FILE: sv/usd_front.sv
`timescale 1ns / 1ps
// front end: takes bytes, classifies them and queues them for the back end
// depends on usd_pkg
module usd_front import usd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic [7:0]     req_data_byte,
   input  logic           req_final_byte,
   output queue_head_type q_head,
   input  logic           q_pop
);

   byte_item_type       fifo_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   byte_item_type       new_item;
   logic                push;
   logic                pop;

   assign req_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign push      = req_valid && req_ready;
   assign pop       = q_pop && (count_ff != '0);

   always_comb begin
      new_item.data       = req_data_byte;
      new_item.final_byte = req_final_byte;
      new_item.need       = lead_need(req_data_byte);
      new_item.trail      = (req_data_byte & TRAIL_MASK) == TRAIL_TAG;
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign q_head.valid = count_ff != '0;
   assign q_head.item  = fifo_ff[rd_ptr_ff];

endmodule

FILE: sv/usd_back.sv
`timescale 1ns / 1ps
// back end: byte window, sequence check, one code point per cycle unless stalled, output register
// depends on usd_pkg
module usd_back import usd_pkg::*; #(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type q_head,
   output logic           q_pop,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic [20:0]    rsp_code_point,
   output logic [2:0]     rsp_byte_length,
   output logic [31:0]    rsp_end_offset,
   output logic           rsp_bad_sequence,
   output logic           rsp_run_last,
   output logic           rsp_text_last
);

   byte_item_type          win_ff [WIN_DEPTH];
   byte_item_type          win_in [WIN_DEPTH];
   logic [2:0]             win_count_ff, win_count_in;
   logic                   win_final_ff, win_final_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [20:0]            code_point_ff;
   logic [2:0]             byte_length_ff;
   logic [31:0]            end_offset_ff;
   logic                   bad_ff, run_last_ff, text_last_ff;

   logic [7:0]  b0, b1, b2, b3;
   logic [2:0]  head_need;
   logic        avail_ok, can_emit, out_room, emit, pull;
   logic [20:0] cp2, cp3, cp4, cp_seq, cp_out;
   logic        trail_ok, min_ok, scalar_ok, seq_ok, ascii;
   logic [2:0]  len, rem_count, rem_need, shift_amt, base_count, src_idx;
   logic        rem_stuck, text_end;
   logic [OFFSET_BITS-1:0] offset_sum;
   logic [OFFSET_BITS+31:0] sum_ext;

   assign b0        = win_ff[0].data;
   assign b1        = win_ff[1].data;
   assign b2        = win_ff[2].data;
   assign b3        = win_ff[3].data;
   assign head_need = win_ff[0].need;
   assign avail_ok  = head_need <= win_count_ff;
   // with the final byte in the window every head is judged, cut off or not
   assign can_emit  = (win_count_ff != 3'd0) && (avail_ok || win_final_ff);
   assign out_room  = !rsp_valid_ff || rsp_ready;
   assign emit      = can_emit && out_room;

   assign cp2 = {10'd0, b0[4:0], b1[5:0]};
   assign cp3 = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
   assign cp4 = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};

   always_comb begin
      case (head_need)
         3'd2: begin
            cp_seq   = cp2;
            trail_ok = win_ff[1].trail;
            min_ok   = cp2 >= CP_MIN_2;
         end
         3'd3: begin
            cp_seq   = cp3;
            trail_ok = win_ff[1].trail && win_ff[2].trail;
            min_ok   = cp3 >= CP_MIN_3;
         end
         3'd4: begin
            cp_seq   = cp4;
            trail_ok = win_ff[1].trail && win_ff[2].trail && win_ff[3].trail;
            min_ok   = cp4 >= CP_MIN_4;
         end
         default: begin
            cp_seq   = '0;
            trail_ok = 1'b0;
            min_ok   = 1'b0;
         end
      endcase
   end

   assign scalar_ok = (cp_seq < SURR_LO) || ((cp_seq >= SURR_END) && (cp_seq <= CP_MAX));
   assign ascii     = !b0[7];
   assign seq_ok    = (head_need > 3'd1) && avail_ok && trail_ok && min_ok && scalar_ok;
   assign cp_out    = ascii ? {13'd0, b0} : (seq_ok ? cp_seq : REPLACEMENT_CP);
   assign len       = seq_ok ? head_need : 3'd1;

   // what is left after this code point, and whether it has to wait for bytes
   assign rem_count = win_count_ff - len;
   assign rem_need  = win_ff[len[1:0]].need;
   assign rem_stuck = (rem_count == 3'd0) || (!win_final_ff && (rem_need > rem_count));
   assign text_end  = win_final_ff && (rem_count == 3'd0);

   // a new byte enters once the window can make no further result
   assign pull  = q_head.valid && (can_emit ? (out_room && rem_stuck) : 1'b1);
   assign q_pop = pull;

   assign shift_amt  = emit ? len : 3'd0;
   assign base_count = emit ? rem_count : win_count_ff;

   always_comb begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
         src_idx   = 3'(i) + shift_amt;
         win_in[i] = win_ff[src_idx[1:0]];
      end
      if (pull) begin
         win_in[base_count[1:0]] = q_head.item;
      end
      win_count_in = base_count + 3'(pull);
      win_final_in = win_final_ff;
      if (emit && text_end) begin
         win_final_in = 1'b0;
      end
      if (pull) begin
         win_final_in = q_head.item.final_byte;
      end
   end

   assign offset_sum = offset_ff + OFFSET_BITS'(len);
   assign sum_ext    = {32'd0, offset_sum};

   always_comb begin
      offset_in = offset_ff;
      if (emit) begin
         offset_in = text_end ? '0 : offset_sum;
      end
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_count_ff <= '0;
         win_final_ff <= 1'b0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         win_count_ff <= win_count_in;
         win_final_ff <= win_final_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (emit) begin
         code_point_ff  <= cp_out;
         byte_length_ff <= len;
         end_offset_ff  <= sum_ext[31:0];
         bad_ff         <= !(ascii || seq_ok);
         run_last_ff    <= rem_stuck;
         text_last_ff   <= text_end;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_code_point   = code_point_ff;
   assign rsp_byte_length  = byte_length_ff;
   assign rsp_end_offset   = end_offset_ff;
   assign rsp_bad_sequence = bad_ff;
   assign rsp_run_last     = run_last_ff;
   assign rsp_text_last    = text_last_ff;

endmodule

FILE: sv/utf8_stream_decoder_core.sv
`timescale 1ns / 1ps
// Streaming UTF-8 decoder with U+FFFD replacement. Bytes enter on the req_ channel and are
// classified and queued (four entries); a back end holds a window of up to four bytes and
// produces at most one code point per cycle on the rsp_ channel, which has its own output
// register. When the output is not held, well-formed text goes through at one byte per
// cycle and the result of a sequence leaves as the next byte enters. A rejected sequence
// gives one replacement result per byte, one per cycle when the output is not held, and
// the byte input waits while those bytes are replayed from the window. The offset counts
// in OFFSET_BITS bits and restarts after the result flagged text_last.
// depends on usd_pkg, usd_front, usd_back
module utf8_stream_decoder_core import usd_pkg::*; #(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [20:0] rsp_code_point,
   output logic [2:0]  rsp_byte_length,
   output logic [31:0] rsp_end_offset,
   output logic        rsp_bad_sequence,
   output logic        rsp_run_last,
   output logic        rsp_text_last
);

   queue_head_type q_head;
   logic           q_pop;

   usd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .q_head         (q_head),
      .q_pop          (q_pop)
   );

   usd_back #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_code_point   (rsp_code_point),
      .rsp_byte_length  (rsp_byte_length),
      .rsp_end_offset   (rsp_end_offset),
      .rsp_bad_sequence (rsp_bad_sequence),
      .rsp_run_last     (rsp_run_last),
      .rsp_text_last    (rsp_text_last)
   );

`ifndef NO_ASSERTIONS
   // the end of the text always closes the results of its byte
   a_text_last_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_text_last |-> rsp_run_last)
      else $error("text_last without run_last");

   // replacement is always a single byte
   a_bad_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_sequence |->
         rsp_code_point == REPLACEMENT_CP && rsp_byte_length == 3'd1)
      else $error("bad sequence result malformed");

   // a good one-byte result is plain ascii
   a_single_ascii: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bad_sequence && rsp_byte_length == 3'd1 |->
         rsp_code_point < 21'h000080)
      else $error("one-byte result out of ascii range");

   // a good result never lands in the surrogate range or past the top
   a_scalar: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bad_sequence |->
         (rsp_code_point < SURR_LO || rsp_code_point >= SURR_END) &&
         rsp_code_point <= CP_MAX)
      else $error("result is not a scalar value");
`endif

endmodule

FILE: sim/utf8_stream_decoder_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for utf8_stream_decoder_core: random utf-8 texts in, decoded code
// points checked against a byte-level decoder kept alongside; depends on usd_pkg and the core
module utf8_stream_decoder_core_tb;
   import usd_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 16;
   localparam int TEXT_BYTES   = 450;

   typedef struct packed {
      logic       pause;
      logic       fin;
      logic [7:0] data;
   } text_byte_type;

   typedef struct packed {
      logic [20:0] cp;
      logic [2:0]  len;
      logic [31:0] offset;
      logic        bad;
      logic        run_last;
      logic        text_last;
   } decoded_type;

   typedef enum logic [1:0] {RX_STEADY, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_final_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [20:0] rsp_code_point;
   logic [2:0]  rsp_byte_length;
   logic [31:0] rsp_end_offset;
   logic        rsp_bad_sequence;
   logic        rsp_run_last;
   logic        rsp_text_last;

   text_byte_type byte_q[$];
   decoded_type   code_point_q[$];
   logic [7:0]    text_buf[$];

   // decoder state mirrored from the byte stream
   logic [7:0]  pend_buf [3];
   int          pend_n = 0;
   logic [31:0] run_offset = '0;

   int errors = 0;
   int bytes_in = 0;
   int texts_in = 0;
   int results_seen = 0;
   int bad_seen = 0;
   int idle_cycles = 0;
   logic req_taken = 1'b0;
   decoded_type want;
   text_byte_type head;

   always #10 clock = ~clock;

   utf8_stream_decoder_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_final_byte   (req_final_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_code_point   (rsp_code_point),
      .rsp_byte_length  (rsp_byte_length),
      .rsp_end_offset   (rsp_end_offset),
      .rsp_bad_sequence (rsp_bad_sequence),
      .rsp_run_last     (rsp_run_last),
      .rsp_text_last    (rsp_text_last)
   );

   function automatic logic [2:0] seq_len(input logic [7:0] b);
      casez (b)
         8'b110?????: return 3'd2;
         8'b1110????: return 3'd3;
         8'b11110???: return 3'd4;
         default:     return 3'd1;
      endcase
   endfunction

   // one accepted byte: emit every sequence that can be judged now
   task automatic decode_byte(input logic [7:0] data, input logic fin);
      logic [7:0]  win [4];
      decoded_type outs [4];
      logic [20:0] v;
      logic [20:0] minv;
      logic [20:0] cpv;
      logic [2:0]  need;
      logic [2:0]  len;
      logic        ok;
      logic        bad;
      int          n;
      int          pos;
      int          k;
      int          i;
      n = pend_n;
      for (i = 0; i < n; i++) win[i] = pend_buf[i];
      win[n] = data;
      n++;
      pos = 0;
      k = 0;
      while (pos < n && k < 4) begin
         need = seq_len(win[pos]);
         if (need > n - pos && !fin) break;
         cpv = REPLACEMENT_CP;
         len = 3'd1;
         bad = 1'b1;
         if (win[pos] < 8'h80) begin
            cpv = {13'd0, win[pos]};
            bad = 1'b0;
         end else if (need > 1 && need <= n - pos) begin
            case (need)
               3'd2: begin
                  v = {16'd0, win[pos][4:0]};
                  minv = CP_MIN_2;
               end
               3'd3: begin
                  v = {17'd0, win[pos][3:0]};
                  minv = CP_MIN_3;
               end
               default: begin
                  v = {18'd0, win[pos][2:0]};
                  minv = CP_MIN_4;
               end
            endcase
            ok = 1'b1;
            for (i = 1; i < need; i++) begin
               if (win[pos + i][7:6] != 2'b10) ok = 1'b0;
               v = {v[14:0], win[pos + i][5:0]};
            end
            if (ok && v >= minv && v <= CP_MAX && !(v >= SURR_LO && v < SURR_END)) begin
               cpv = v;
               len = need;
               bad = 1'b0;
            end
         end
         run_offset = run_offset + len;
         outs[k] = '{cpv, len, run_offset, bad, 1'b0, 1'b0};
         k++;
         pos += len;
      end
      if (k > 0) begin
         outs[k - 1].run_last = 1'b1;
         outs[k - 1].text_last = fin;
      end
      for (i = 0; i < k; i++) code_point_q.insert(code_point_q.size(), outs[i]);
      if (fin || pos >= n) begin
         pend_n = 0;
      end else begin
         pend_n = n - pos;
         for (i = 0; i < pend_n; i++) pend_buf[i] = win[pos + i];
      end
      if (fin) run_offset = '0;
   endtask

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want_v, got_v);
         errors++;
      end
   endtask

   task automatic push_byte(input logic [7:0] data, input logic fin, input logic pause);
      text_byte_type t;
      t.pause = pause;
      t.fin = fin;
      t.data = data;
      byte_q.insert(byte_q.size(), t);
   endtask

   // append one raw byte to the text under construction
   task automatic add_byte(input logic [7:0] b);
      text_buf.insert(text_buf.size(), b);
   endtask

   // encode c in exactly nb bytes, whether or not that is the shortest form
   task automatic put_cp(input logic [20:0] c, input int nb);
      case (nb)
         1: add_byte({1'b0, c[6:0]});
         2: begin
            add_byte({3'b110, c[10:6]});
            add_byte({2'b10, c[5:0]});
         end
         3: begin
            add_byte({4'b1110, c[15:12]});
            add_byte({2'b10, c[11:6]});
            add_byte({2'b10, c[5:0]});
         end
         default: begin
            add_byte({5'b11110, c[20:18]});
            add_byte({2'b10, c[17:12]});
            add_byte({2'b10, c[11:6]});
            add_byte({2'b10, c[5:0]});
         end
      endcase
   endtask

   // random text, mostly well formed, sometimes damaged or cut short
   task automatic add_text();
      int chars;
      int kind;
      int nb;
      int pos;
      int c;
      text_buf.delete();
      chars = $urandom_range(1, 10);
      repeat (chars) begin
         kind = $urandom_range(0, 19);
         case (kind)
            0, 1, 2, 3, 4, 5: put_cp(21'($urandom_range(0, 'h7F)), 1);
            6, 7, 8, 9:       put_cp(21'($urandom_range('h80, 'h7FF)), 2);
            10, 11, 12, 13: begin
               c = $urandom_range('h800, 'hF7FF);
               if (c >= 'hD800) c += 'h800;
               put_cp(21'(c), 3);
            end
            14, 15, 16: put_cp(21'($urandom_range('h10000, 'h10FFFF)), 4);
            17: begin
               // overlong form
               nb = $urandom_range(2, 4);
               c = $urandom_range(0, nb == 2 ? 'h7F : (nb == 3 ? 'h7FF : 'hFFFF));
               put_cp(21'(c), nb);
            end
            18: begin
               if ($urandom_range(0, 1)) put_cp(21'($urandom_range('hD800, 'hDFFF)), 3);
               else put_cp(21'($urandom_range('h110000, 'h1FFFFF)), 4);
            end
            default: add_byte(8'($urandom_range(0, 255)));
         endcase
      end
      if ($urandom_range(0, 3) == 0) begin
         pos = $urandom_range(0, text_buf.size() - 1);
         if ($urandom_range(0, 1)) text_buf[pos] = 8'($urandom_range(0, 255));
         else if (text_buf.size() > 1) text_buf.delete(pos);
      end
      if ($urandom_range(0, 5) == 0 && text_buf.size() > 1) void'(text_buf.pop_back());
      foreach (text_buf[i]) push_byte(text_buf[i], i == text_buf.size() - 1, 1'b0);
      if ($urandom_range(0, 5) == 0) push_byte(8'h00, 1'b0, 1'b1);
   endtask

   // sender: bursts and gaps, holds each transfer until taken
   int gap_left = 0;
   int burst_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data_byte <= '0;
         req_final_byte <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (byte_q.size() != 0) head = byte_q[0];
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (byte_q.size() != 0 && head.pause) begin
            // wait for every outstanding code point before going on
            req_valid <= 1'b0;
            if (code_point_q.size() == 0) void'(byte_q.pop_front());
         end else if (byte_q.size() != 0) begin
            void'(byte_q.pop_front());
            req_valid <= 1'b1;
            req_data_byte <= head.data;
            req_final_byte <= head.fin;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern of its own, plus two long hold-offs
   rx_mode_type rx_mode = RX_STEADY;
   int          mode_left = 0;
   int          hold_left = 0;
   int          long_holds = 0;
   logic [1:0]  toggle_cnt = '0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (hold_left == 0 && long_holds < 2 && results_seen >= 120 + 180 * long_holds) begin
            hold_left = 60;
            long_holds++;
         end
         if (mode_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 96);
         end else begin
            mode_left--;
         end
         toggle_cnt++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_STEADY: rsp_ready <= 1'b1;
               RX_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
               RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_ready <= (toggle_cnt != 2'd3);
            endcase
         end
      end
   end

   // monitor: predict on each byte transfer, check each result transfer
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         idle_cycles = 0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            decode_byte(req_data_byte, req_final_byte);
            bytes_in++;
            if (req_final_byte) texts_in++;
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (rsp_bad_sequence) bad_seen++;
            if (code_point_q.size() == 0) begin
               $display("%0t: unexpected result: code_point %0h length %0d offset %0h", $time,
                        rsp_code_point, rsp_byte_length, rsp_end_offset);
               errors++;
            end else begin
               want = code_point_q.pop_front();
               check_field("code_point", want.cp, rsp_code_point);
               check_field("byte_length", want.len, rsp_byte_length);
               check_field("end_offset", want.offset, rsp_end_offset);
               check_field("bad_sequence", want.bad, rsp_bad_sequence);
               check_field("run_last", want.run_last, rsp_run_last);
               check_field("text_last", want.text_last, rsp_text_last);
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   logic [7:0] directed [21] = '{
      8'h00, 8'h7F,                   // ascii extremes
      8'hC2, 8'h80,                   // smallest two-byte form
      8'hED, 8'hA0, 8'h80,            // surrogate
      8'hF4, 8'h90, 8'h80, 8'h80,     // above the last scalar value
      8'hF4, 8'h8F, 8'hBF, 8'hBF,     // last scalar value
      8'hC0, 8'hAF,                   // overlong
      8'h80, 8'hFF,                   // bytes that cannot lead
      8'hE2, 8'h82                    // text cut off inside a sequence
   };

   initial begin
      foreach (directed[i]) push_byte(directed[i], i == 20, 1'b0);
      push_byte(8'h00, 1'b0, 1'b1);
      while (byte_q.size() < TEXT_BYTES) add_text();
      // make sure the last text is closed by a final byte
      push_byte(8'h41, 1'b1, 1'b0);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (byte_q.size() != 0 || req_valid || code_point_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("decoded %0d bytes in %0d texts into %0d code points", bytes_in, texts_in,
               results_seen);
      $display("%0d replacements for bad or cut-off sequences, %0d long receiver hold-offs",
               bad_seen, long_holds);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
